// ===== rtl/frf_pkg.sv =====
// Package for the flood relay filter: field widths, sizes, codes and item types.
// Used by the channel interfaces and by the top level; depends on nothing else.
`timescale 1ns / 1ps

package frf_pkg;

    localparam int NODES       = 64;
    localparam int SEQS        = 256;
    localparam int QUEUE_DEPTH = 16;

    localparam int FUNC_W   = 2;
    localparam int POS_W    = 16;
    localparam int SRC_W    = 6;
    localparam int SEQ_W    = 8;
    localparam int TTL_W    = 8;
    localparam int HOP_W    = 8;
    localparam int HANDLE_W = 16;
    localparam int ACTION_W = 3;
    localparam int RANGE_W  = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RANGE_W;

    localparam int NODE_IDX_W  = $clog2(NODES);
    localparam int SEQ_IDX_W   = $clog2(SEQS);
    localparam int SEEN_IDX_W  = NODE_IDX_W + SEQ_IDX_W;
    localparam int SEEN_ROW_W  = 32;
    localparam int SEEN_BIT_W  = $clog2(SEEN_ROW_W);
    localparam int SEEN_ROWS   = (NODES * SEQS) / SEEN_ROW_W;
    localparam int SEEN_ADDR_W = $clog2(SEEN_ROWS);

    localparam int QA_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int DIFF_W = POS_W + 1;
    localparam int SQ_W   = 2 * POS_W;
    localparam int R2_W   = 2 * RANGE_W;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HOP   = 2'd2;

    localparam logic [RANGE_W-1:0] RANGE_RESET   = 15'd400;
    localparam logic [TTL_W-1:0]   MAX_HOP_RESET = 8'd16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RX    = 2'd0,
        FUNC_LOCAL = 2'd1,
        FUNC_TIMER = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [ACTION_W-1:0] {
        ACT_DROP_RANGE = 3'd0,
        ACT_DROP_DUP   = 3'd1,
        ACT_DROP_TTL   = 3'd2,
        ACT_DELIVER    = 3'd3,
        ACT_SEND_OWN   = 3'd4,
        ACT_SEND_RELAY = 3'd5,
        ACT_IDLE       = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic signed [POS_W-1:0] own_x;
        logic signed [POS_W-1:0] own_y;
        logic signed [POS_W-1:0] sender_x;
        logic signed [POS_W-1:0] sender_y;
        logic [SRC_W-1:0]    src_id;
        logic [SEQ_W-1:0]    seq_num;
        logic [TTL_W-1:0]    ttl_in;
        logic [HOP_W-1:0]    hop_in;
        logic [HANDLE_W-1:0] payload_handle;
    } t_item;

    typedef struct packed {
        logic [SRC_W-1:0]    src;
        logic [SEQ_W-1:0]    seq;
        logic [HOP_W-1:0]    hop;
        logic [TTL_W-1:0]    ttl;
        logic [HANDLE_W-1:0] handle;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } t_entry;

    typedef struct packed {
        t_action             action;
        logic                relay_overflow;
        logic                arm_timer;
        logic [SRC_W-1:0]    tx_src;
        logic [SEQ_W-1:0]    tx_seq;
        logic signed [POS_W-1:0] tx_sender_x;
        logic signed [POS_W-1:0] tx_sender_y;
        logic [HOP_W-1:0]    tx_hop;
        logic [TTL_W-1:0]    tx_ttl;
        logic [HANDLE_W-1:0] tx_handle;
    } t_result;

    function automatic logic [SEEN_IDX_W-1:0] seen_index(
        input logic [SRC_W-1:0] src,
        input logic [SEQ_W-1:0] seq
    );
        seen_index = {src[NODE_IDX_W-1:0], seq[SEQ_IDX_W-1:0]};
    endfunction

endpackage

// ===== rtl/frf_ifs.sv =====
// Valid/ready channel interfaces for the flood relay filter input and result items.
// Depends on frf_pkg for field widths.
`timescale 1ns / 1ps

interface frf_in_if;
    logic valid;
    logic ready;
    logic [frf_pkg::FUNC_W-1:0]   func;
    logic signed [frf_pkg::POS_W-1:0] own_x;
    logic signed [frf_pkg::POS_W-1:0] own_y;
    logic signed [frf_pkg::POS_W-1:0] sender_x;
    logic signed [frf_pkg::POS_W-1:0] sender_y;
    logic [frf_pkg::SRC_W-1:0]    src_id;
    logic [frf_pkg::SEQ_W-1:0]    seq_num;
    logic [frf_pkg::TTL_W-1:0]    ttl_in;
    logic [frf_pkg::HOP_W-1:0]    hop_in;
    logic [frf_pkg::HANDLE_W-1:0] payload_handle;

    modport source (
        output valid, func, own_x, own_y, sender_x, sender_y,
               src_id, seq_num, ttl_in, hop_in, payload_handle,
        input  ready
    );
    modport sink (
        input  valid, func, own_x, own_y, sender_x, sender_y,
               src_id, seq_num, ttl_in, hop_in, payload_handle,
        output ready
    );
endinterface

interface frf_out_if;
    logic valid;
    logic ready;
    logic [frf_pkg::ACTION_W-1:0] action;
    logic                         relay_overflow;
    logic                         arm_timer;
    logic [frf_pkg::SRC_W-1:0]    tx_src;
    logic [frf_pkg::SEQ_W-1:0]    tx_seq;
    logic signed [frf_pkg::POS_W-1:0] tx_sender_x;
    logic signed [frf_pkg::POS_W-1:0] tx_sender_y;
    logic [frf_pkg::HOP_W-1:0]    tx_hop;
    logic [frf_pkg::TTL_W-1:0]    tx_ttl;
    logic [frf_pkg::HANDLE_W-1:0] tx_handle;

    modport source (
        output valid, action, relay_overflow, arm_timer, tx_src, tx_seq,
               tx_sender_x, tx_sender_y, tx_hop, tx_ttl, tx_handle,
        input  ready
    );
    modport sink (
        input  valid, action, relay_overflow, arm_timer, tx_src, tx_seq,
               tx_sender_x, tx_sender_y, tx_hop, tx_ttl, tx_handle,
        output ready
    );
endinterface

// ===== rtl/flood_relay_filter.sv =====
// Flood relay filter top level: seen bitmap memory, relay queue memory and control.
// Depends on frf_pkg and the channel interfaces in frf_ifs.sv.
//
//   Channel   Direction  Transaction
//   i_in      in         one received packet, local send or relay timer event
//   o_out     out        one action with the transmitted or delivered header
//   i_cfg_*   in         one register write, no handshake
//
// An item passes a read cycle on both memories with the squares computed, then a
// decide cycle that writes back.
// The next item is accepted in the decide cycle, set by the single seen-map port.
// After reset a clearing pass zeroes all 512 rows of the seen map; no item is taken.
// A stalled result holds the decide cycle until the result register is free.
`timescale 1ns / 1ps

module flood_relay_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [frf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [frf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    frf_in_if.sink                             i_in,
    frf_out_if.source                          o_out
);
    import frf_pkg::*;

    t_state                 r_state, n_state;
    logic [SEEN_ADDR_W-1:0] r_clr_addr;
    logic [SRC_W-1:0]       r_own_id;
    logic [RANGE_W-1:0]     r_range;
    logic [TTL_W-1:0]       r_max_hop;
    logic [SEQ_W-1:0]       r_local_seq;
    logic [QA_W-1:0]        r_head;
    logic [CNT_W-1:0]       r_count;
    t_item                  r_item;
    logic [SQ_W-1:0]        r_dx2, r_dy2;
    logic [R2_W-1:0]        r_r2;
    logic [SEEN_ROW_W-1:0]  r_seen_rd;
    t_entry                 r_q_rd;
    logic                   r_out_valid;
    t_result                r_out;

    logic [SEEN_ROW_W-1:0]  seen_mem [SEEN_ROWS];
    t_entry                 queue_mem [QUEUE_DEPTH];

    logic                   w_accept;
    logic                   w_can_load;
    logic                   w_load;
    logic                   w_rd_en;
    logic                   w_seen_mark;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_seq_inc;
    logic                   w_seen_we;
    logic [SEEN_ADDR_W-1:0] w_seen_addr;
    logic [SEEN_ADDR_W-1:0] w_seen_waddr;
    logic [SEEN_ROW_W-1:0]  w_seen_wdata;
    logic [SEEN_IDX_W-1:0]  w_idx;
    logic                   w_seen_bit;
    logic [QA_W-1:0]        w_tail;
    logic                   w_full;
    logic signed [DIFF_W-1:0]   w_dx, w_dy;
    logic signed [2*DIFF_W-1:0] w_dx2, w_dy2;
    logic [SQ_W:0]          w_d2;
    t_entry                 w_entry;
    t_result                w_res;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_can_load = !r_out_valid || o_out.ready;

    // Seen-map row and bit for the item in flight; source and sequence are held stable.
    always_comb begin
        if (t_func'(r_item.func) == FUNC_LOCAL) begin
            w_idx = seen_index(r_own_id, r_local_seq);
        end else begin
            w_idx = seen_index(r_item.src_id, r_item.seq_num);
        end
    end
    assign w_seen_addr = w_idx[SEEN_IDX_W-1:SEEN_BIT_W];
    assign w_seen_bit  = r_seen_rd[w_idx[SEEN_BIT_W-1:0]];
    assign w_tail      = r_head + r_count[QA_W-1:0];
    assign w_full      = (r_count == CNT_W'(QUEUE_DEPTH));

    assign w_dx  = DIFF_W'(r_item.own_x) - DIFF_W'(r_item.sender_x);
    assign w_dy  = DIFF_W'(r_item.own_y) - DIFF_W'(r_item.sender_y);
    assign w_dx2 = w_dx * w_dx;
    assign w_dy2 = w_dy * w_dy;
    assign w_d2  = {1'b0, r_dx2} + {1'b0, r_dy2};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == SEEN_ADDR_W'(SEEN_ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (w_accept) begin
                    n_state = ST_READ;
                end else if (w_can_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_in.ready  = 1'b0;
        w_rd_en     = 1'b0;
        w_load      = 1'b0;
        w_seen_mark = 1'b0;
        w_push      = 1'b0;
        w_pop       = 1'b0;
        w_seq_inc   = 1'b0;
        w_res       = '0;
        w_res.action = ACT_IDLE;
        w_entry.src    = r_item.src_id;
        w_entry.seq    = r_item.seq_num;
        w_entry.hop    = r_item.hop_in + 1'b1;
        w_entry.ttl    = r_item.ttl_in - 1'b1;
        w_entry.handle = r_item.payload_handle;
        w_entry.x      = r_item.own_x;
        w_entry.y      = r_item.own_y;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            ST_READ: begin
                w_rd_en = 1'b1;
            end
            ST_DECIDE: begin
                i_in.ready = w_can_load;
                w_load     = w_can_load;
                case (t_func'(r_item.func))
                    FUNC_RX: begin
                        if (w_d2 > (SQ_W + 1)'(r_r2)) begin
                            w_res.action = ACT_DROP_RANGE;
                        end else begin
                            w_seen_mark = 1'b1;
                            if (w_seen_bit) begin
                                w_res.action = ACT_DROP_DUP;
                            end else if (r_item.ttl_in == '0) begin
                                w_res.action = ACT_DROP_TTL;
                            end else begin
                                w_res.action    = ACT_DELIVER;
                                w_res.tx_handle = r_item.payload_handle;
                                if (r_item.ttl_in > TTL_W'(1)) begin
                                    if (w_full) begin
                                        w_res.relay_overflow = 1'b1;
                                    end else begin
                                        w_push          = 1'b1;
                                        w_res.arm_timer = (r_count == '0);
                                    end
                                end
                            end
                        end
                    end
                    FUNC_LOCAL: begin
                        w_seen_mark       = 1'b1;
                        w_seq_inc         = 1'b1;
                        w_res.action      = ACT_SEND_OWN;
                        w_res.tx_src      = r_own_id;
                        w_res.tx_seq      = r_local_seq;
                        w_res.tx_sender_x = r_item.own_x;
                        w_res.tx_sender_y = r_item.own_y;
                        w_res.tx_ttl      = r_max_hop;
                        w_res.tx_handle   = r_item.payload_handle;
                    end
                    FUNC_TIMER: begin
                        if (r_count != '0) begin
                            w_pop             = 1'b1;
                            w_res.action      = ACT_SEND_RELAY;
                            w_res.arm_timer   = (r_count > CNT_W'(1));
                            w_res.tx_src      = r_q_rd.src;
                            w_res.tx_seq      = r_q_rd.seq;
                            w_res.tx_sender_x = r_q_rd.x;
                            w_res.tx_sender_y = r_q_rd.y;
                            w_res.tx_hop      = r_q_rd.hop;
                            w_res.tx_ttl      = r_q_rd.ttl;
                            w_res.tx_handle   = r_q_rd.handle;
                        end
                    end
                    default: begin
                        w_res.action = ACT_IDLE;
                    end
                endcase
            end
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_seen_we    = 1'b0;
        w_seen_waddr = w_seen_addr;
        w_seen_wdata = r_seen_rd | (SEEN_ROW_W'(1) << w_idx[SEEN_BIT_W-1:0]);
        if (r_state == ST_CLEAR) begin
            w_seen_we    = 1'b1;
            w_seen_waddr = r_clr_addr;
            w_seen_wdata = '0;
        end else if (w_load && w_seen_mark) begin
            w_seen_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_seen_we) begin
            seen_mem[w_seen_waddr] <= w_seen_wdata;
        end
        if (w_rd_en) begin
            r_seen_rd <= seen_mem[w_seen_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && w_push) begin
            queue_mem[w_tail] <= w_entry;
        end
        if (w_rd_en) begin
            r_q_rd <= queue_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.func           <= i_in.func;
            r_item.own_x          <= i_in.own_x;
            r_item.own_y          <= i_in.own_y;
            r_item.sender_x       <= i_in.sender_x;
            r_item.sender_y       <= i_in.sender_y;
            r_item.src_id         <= i_in.src_id;
            r_item.seq_num        <= i_in.seq_num;
            r_item.ttl_in         <= i_in.ttl_in;
            r_item.hop_in         <= i_in.hop_in;
            r_item.payload_handle <= i_in.payload_handle;
        end
        if (w_rd_en) begin
            r_dx2 <= w_dx2[SQ_W-1:0];
            r_dy2 <= w_dy2[SQ_W-1:0];
            r_r2  <= R2_W'(r_range) * R2_W'(r_range);
        end
        if (w_load) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_own_id    <= '0;
            r_range     <= RANGE_RESET;
            r_max_hop   <= MAX_HOP_RESET;
            r_local_seq <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OWN_ID:  r_own_id  <= i_cfg_data[SRC_W-1:0];
                    REG_RANGE:   r_range   <= i_cfg_data[RANGE_W-1:0];
                    REG_MAX_HOP: r_max_hop <= i_cfg_data[TTL_W-1:0];
                    default:     r_own_id  <= r_own_id;
                endcase
            end
            if (w_load && w_seq_inc) begin
                r_local_seq <= r_local_seq + 1'b1;
            end
            if (w_load && w_pop) begin
                r_head  <= r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end else if (w_load && w_push) begin
                r_count <= r_count + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.action         = r_out.action;
    assign o_out.relay_overflow = r_out.relay_overflow;
    assign o_out.arm_timer      = r_out.arm_timer;
    assign o_out.tx_src         = r_out.tx_src;
    assign o_out.tx_seq         = r_out.tx_seq;
    assign o_out.tx_sender_x    = r_out.tx_sender_x;
    assign o_out.tx_sender_y    = r_out.tx_sender_y;
    assign o_out.tx_hop         = r_out.tx_hop;
    assign o_out.tx_ttl         = r_out.tx_ttl;
    assign o_out.tx_handle      = r_out.tx_handle;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("relay queue count beyond depth");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_READ))
        else $error("accepted item did not start a memory read");

    a_overflow_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.relay_overflow) |-> (o_out.action == ACT_DELIVER))
        else $error("relay overflow flagged on a non-deliver result");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_pop) |=> (r_count == $past(r_count) - 1'b1))
        else $error("relay pop did not decrement the queue count");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |=> !r_out_valid)
        else $error("result produced during seen map clearing");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for flood_relay_filter: a directed table, then random traffic.
// Depends on frf_pkg and the channel interfaces in frf_ifs.sv, plus the top level itself.

module tb_top;
    import frf_pkg::*;

    localparam int SEGMENTS       = 6;
    localparam int SEG_ITEMS      = 330;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int PAIR_POOL      = 64;

    typedef struct {
        t_item   it;
        bit      known;
        t_result want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    frf_in_if  in_ch ();
    frf_out_if out_ch ();

    flood_relay_filter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    logic [SRC_W-1:0]   cfg_own_id  = '0;
    logic [RANGE_W-1:0] cfg_range   = RANGE_RESET;
    logic [TTL_W-1:0]   cfg_max_hop = MAX_HOP_RESET;

    bit               seen_bits [NODES*SEQS];
    logic [SEQ_W-1:0] local_seq = '0;
    t_entry           relay_fifo [$];
    t_result          awaited_results [$];

    int tx_idle_pct = 13;
    int rx_idle_pct = 87;
    bit hold_armed;
    bit hold_done;
    int hold_left;
    int mismatches;
    int stall_cycles;

    int                       burst_left;
    t_func                    burst_func;
    logic [SRC_W+SEQ_W-1:0]   recent_pairs [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result bare(input t_action act);
        t_result r;
        r = '0;
        r.action = act;
        return r;
    endfunction

    function automatic t_item mk_item(input int func, input int ox, input int oy, input int sx,
                                      input int sy, input int src, input int seq, input int ttl,
                                      input int hop, input int handle);
        t_item it;
        it.func           = FUNC_W'(func);
        it.own_x          = POS_W'(ox);
        it.own_y          = POS_W'(oy);
        it.sender_x       = POS_W'(sx);
        it.sender_y       = POS_W'(sy);
        it.src_id         = SRC_W'(src);
        it.seq_num        = SEQ_W'(seq);
        it.ttl_in         = TTL_W'(ttl);
        it.hop_in         = HOP_W'(hop);
        it.payload_handle = HANDLE_W'(handle);
        return it;
    endfunction

    function automatic string show(input t_result r);
        return $sformatf({"action=%0d ovf=%0b arm=%0b src=%0d seq=%0d x=%0d y=%0d ",
                          "hop=%0d ttl=%0d handle=%h"},
                         r.action, r.relay_overflow, r.arm_timer, r.tx_src, r.tx_seq,
                         r.tx_sender_x, r.tx_sender_y, r.tx_hop, r.tx_ttl, r.tx_handle);
    endfunction

    function automatic t_result decide_action(input t_item it);
        t_result res;
        t_entry  ent;
        longint  dx;
        longint  dy;
        longint  d2;
        longint  r2;
        int      bit_idx;
        res = bare(ACT_IDLE);
        case (t_func'(it.func))
            FUNC_RX: begin
                dx = longint'($signed(it.own_x)) - longint'($signed(it.sender_x));
                dy = longint'($signed(it.own_y)) - longint'($signed(it.sender_y));
                d2 = dx * dx + dy * dy;
                r2 = longint'(cfg_range) * longint'(cfg_range);
                bit_idx = int'(it.src_id) * SEQS + int'(it.seq_num);
                if (d2 > r2) begin
                    res.action = ACT_DROP_RANGE;
                end else if (seen_bits[bit_idx]) begin
                    res.action = ACT_DROP_DUP;
                end else begin
                    seen_bits[bit_idx] = 1'b1;
                    if (it.ttl_in == 0) begin
                        res.action = ACT_DROP_TTL;
                    end else begin
                        res.action = ACT_DELIVER;
                        res.tx_handle = it.payload_handle;
                        if (it.ttl_in > 1) begin
                            if (relay_fifo.size() >= QUEUE_DEPTH) begin
                                res.relay_overflow = 1'b1;
                            end else begin
                                ent.src    = it.src_id;
                                ent.seq    = it.seq_num;
                                ent.hop    = it.hop_in + 8'd1;
                                ent.ttl    = it.ttl_in - 8'd1;
                                ent.handle = it.payload_handle;
                                ent.x      = it.own_x;
                                ent.y      = it.own_y;
                                relay_fifo.push_back(ent);
                                res.arm_timer = (relay_fifo.size() == 1);
                            end
                        end
                    end
                end
            end
            FUNC_LOCAL: begin
                seen_bits[int'(cfg_own_id) * SEQS + int'(local_seq)] = 1'b1;
                res.action      = ACT_SEND_OWN;
                res.tx_src      = cfg_own_id;
                res.tx_seq      = local_seq;
                res.tx_sender_x = it.own_x;
                res.tx_sender_y = it.own_y;
                res.tx_ttl      = cfg_max_hop;
                res.tx_handle   = it.payload_handle;
                local_seq = local_seq + 8'd1;
            end
            FUNC_TIMER: begin
                if (relay_fifo.size() > 0) begin
                    ent = relay_fifo.pop_front();
                    res.action      = ACT_SEND_RELAY;
                    res.arm_timer   = (relay_fifo.size() > 0);
                    res.tx_src      = ent.src;
                    res.tx_seq      = ent.seq;
                    res.tx_sender_x = ent.x;
                    res.tx_sender_y = ent.y;
                    res.tx_hop      = ent.hop;
                    res.tx_ttl      = ent.ttl;
                    res.tx_handle   = ent.handle;
                end
            end
            default: begin
                res.action = ACT_IDLE;
            end
        endcase
        return res;
    endfunction

    function automatic t_item gen_item();
        t_item it;
        int    pick;
        int    r;
        int    radius;
        int    dx;
        int    dy;
        it.own_x          = POS_W'($urandom);
        it.own_y          = POS_W'($urandom);
        it.sender_x       = POS_W'($urandom);
        it.sender_y       = POS_W'($urandom);
        it.src_id         = SRC_W'($urandom);
        it.seq_num        = SEQ_W'($urandom);
        it.ttl_in         = TTL_W'($urandom);
        it.hop_in         = HOP_W'($urandom);
        it.payload_handle = HANDLE_W'($urandom);
        if (burst_left > 0) begin
            burst_left--;
            it.func = burst_func;
        end else begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < 3) begin
                burst_left = $urandom_range(28, 16);
                burst_func = $urandom_range(1) ? FUNC_RX : FUNC_TIMER;
            end
            if (pick < 50) begin
                it.func = FUNC_RX;
            end else if (pick < 65) begin
                it.func = FUNC_LOCAL;
            end else if (pick < 92) begin
                it.func = FUNC_TIMER;
            end else begin
                it.func = FUNC_NONE;
            end
        end
        if (t_func'(it.func) == FUNC_RX) begin
            pick = $urandom_range(99);
            if (pick < 30 && recent_pairs.size() > 0) begin
                {it.src_id, it.seq_num} = recent_pairs[$urandom_range(recent_pairs.size() - 1)];
            end else if (pick < 35) begin
                it.src_id = cfg_own_id;
            end
            recent_pairs.push_back({it.src_id, it.seq_num});
            if (recent_pairs.size() > PAIR_POOL) begin
                void'(recent_pairs.pop_front());
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
                it.ttl_in = '0;
            end else if (pick < 16) begin
                it.ttl_in = 8'd1;
            end
            r = int'(cfg_range);
            pick = $urandom_range(99);
            if (pick >= 10) begin
                if (pick < 25) begin
                    radius = r + int'($urandom_range(1));
                    dx = 0;
                    dy = 0;
                    case ($urandom_range(3))
                        0: dx = radius;
                        1: dx = -radius;
                        2: dy = radius;
                        default: dy = -radius;
                    endcase
                end else begin
                    dx = int'($urandom_range(r)) - r / 2;
                    dy = int'($urandom_range(r)) - r / 2;
                end
                it.sender_x = POS_W'(int'(it.own_x) + dx);
                it.sender_y = POS_W'(int'(it.own_y) + dy);
            end
        end
        return it;
    endfunction

    task automatic send_item(input t_item it, input bit known, input t_result want);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.func           <= it.func;
        in_ch.own_x          <= it.own_x;
        in_ch.own_y          <= it.own_y;
        in_ch.sender_x       <= it.sender_x;
        in_ch.sender_y       <= it.sender_y;
        in_ch.src_id         <= it.src_id;
        in_ch.seq_num        <= it.seq_num;
        in_ch.ttl_in         <= it.ttl_in;
        in_ch.hop_in         <= it.hop_in;
        in_ch.payload_handle <= it.payload_handle;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (known) begin
            void'(decide_action(it));
            awaited_results.push_back(want);
        end else begin
            awaited_results.push_back(decide_action(it));
        end
    endtask

    task automatic set_config(input logic [SRC_W-1:0] own, input logic [RANGE_W-1:0] reach,
                              input logic [TTL_W-1:0] hops);
        while (awaited_results.size() != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_OWN_ID;
        i_cfg_data <= CFG_DATA_W'(own);
        @(posedge i_clk);
        cfg_own_id = own;
        i_cfg_idx  <= REG_RANGE;
        i_cfg_data <= reach;
        @(posedge i_clk);
        cfg_range = reach;
        i_cfg_idx  <= REG_MAX_HOP;
        i_cfg_data <= CFG_DATA_W'(hops);
        @(posedge i_clk);
        cfg_max_hop = hops;
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.action         = t_action'(out_ch.action);
            got.relay_overflow = out_ch.relay_overflow;
            got.arm_timer      = out_ch.arm_timer;
            got.tx_src         = out_ch.tx_src;
            got.tx_seq         = out_ch.tx_seq;
            got.tx_sender_x    = out_ch.tx_sender_x;
            got.tx_sender_y    = out_ch.tx_sender_y;
            got.tx_hop         = out_ch.tx_hop;
            got.tx_ttl         = out_ch.tx_ttl;
            got.tx_handle      = out_ch.tx_handle;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("Result with nothing awaited: %s", show(got));
                end
            end else begin
                want = awaited_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("Result mismatch, expected %s", show(want));
                        $display("                   actual %s", show(got));
                    end
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_row    dir_rows [$];
        t_result want;
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= REG_OWN_ID;
        i_cfg_data           <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.func           <= FUNC_NONE;
        in_ch.own_x          <= '0;
        in_ch.own_y          <= '0;
        in_ch.sender_x       <= '0;
        in_ch.sender_y       <= '0;
        in_ch.src_id         <= '0;
        in_ch.seq_num        <= '0;
        in_ch.ttl_in         <= '0;
        in_ch.hop_in         <= '0;
        in_ch.payload_handle <= '0;

        dir_rows.push_back('{mk_item(FUNC_TIMER, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, bare(ACT_IDLE)});
        dir_rows.push_back('{mk_item(FUNC_NONE, 32767, -32768, -1, 1, 63, 255, 255, 255, 65535),
                             1'b1, bare(ACT_IDLE)});
        dir_rows.push_back('{mk_item(FUNC_RX, 0, 0, 401, 0, 1, 1, 5, 0, 1),
                             1'b1, bare(ACT_DROP_RANGE)});
        dir_rows.push_back('{mk_item(FUNC_RX, -32768, -32768, 32767, 32767, 1, 1, 5, 0, 2),
                             1'b1, bare(ACT_DROP_RANGE)});
        dir_rows.push_back('{mk_item(FUNC_RX, 0, 0, 400, 0, 1, 1, 5, 0, 65535),
                             1'b0, bare(ACT_IDLE)});
        dir_rows.push_back('{mk_item(FUNC_RX, 10, 10, 10, 10, 1, 1, 9, 0, 3),
                             1'b1, bare(ACT_DROP_DUP)});
        dir_rows.push_back('{mk_item(FUNC_RX, 0, 0, 0, -400, 2, 0, 0, 0, 4),
                             1'b1, bare(ACT_DROP_TTL)});
        dir_rows.push_back('{mk_item(FUNC_RX, 5, 5, 5, 5, 63, 255, 1, 255, 0),
                             1'b0, bare(ACT_IDLE)});
        dir_rows.push_back('{mk_item(FUNC_RX, 32767, -32768, 32527, -32448, 3, 9, 255, 255,
                                     16'h5A5A),
                             1'b0, bare(ACT_IDLE)});
        for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            dir_rows.push_back('{mk_item(FUNC_RX, k * 1000, -k * 1000, k * 1000 + 3, -k * 1000 - 4,
                                         20 + k, k * 17, 2 + k * 17, k * 18, 16'hA000 + k),
                                 1'b0, bare(ACT_IDLE)});
        end
        dir_rows.push_back('{mk_item(FUNC_TIMER, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, bare(ACT_IDLE)});
        want = bare(ACT_SEND_OWN);
        want.tx_sender_x = -16'sd1;
        want.tx_sender_y = -16'sd1;
        want.tx_ttl      = MAX_HOP_RESET;
        want.tx_handle   = 16'h1234;
        dir_rows.push_back('{mk_item(FUNC_LOCAL, -1, -1, 7, 7, 9, 9, 9, 9, 16'h1234), 1'b1, want});
        dir_rows.push_back('{mk_item(FUNC_RX, 0, 0, 0, 0, 0, 0, 3, 0, 5),
                             1'b1, bare(ACT_DROP_DUP)});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].it, dir_rows[i].known, dir_rows[i].want);
        end
        in_ch.valid <= 1'b0;

        for (int s = 0; s < SEGMENTS; s++) begin
            case (s)
                0: set_config(6'd63, 15'd32767, 8'd255);
                1: set_config(6'd0, 15'd0, 8'd0);
                2: set_config(SRC_W'($urandom), RANGE_W'($urandom_range(3000, 200)),
                              TTL_W'($urandom));
                3: set_config(SRC_W'($urandom), 15'd32767, 8'd1);
                4: set_config(SRC_W'($urandom), RANGE_W'($urandom_range(800, 1)),
                              TTL_W'($urandom));
                default: set_config(6'd42, RANGE_RESET, MAX_HOP_RESET);
            endcase
            case (s / 2)
                0: begin
                    tx_idle_pct = 13;
                    rx_idle_pct = 87;
                end
                1: begin
                    tx_idle_pct = 87;
                    rx_idle_pct = 13;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (s == SEGMENTS - 2) begin
                hold_armed = 1'b1;
            end
            repeat (SEG_ITEMS) begin
                send_item(gen_item(), 1'b0, bare(ACT_IDLE));
            end
            in_ch.valid <= 1'b0;
        end

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== flood_relay_filter.f =====
rtl/frf_pkg.sv
rtl/frf_ifs.sv
rtl/flood_relay_filter.sv
tb/tb_top.sv
